// File: rtl/stereo_to_mono_linear_resampler_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo-to-mono resampler
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STEREO_TO_MONO_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define STEREO_TO_MONO_LINEAR_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define STMLR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stmlr: same-cycle property violated");

`define STMLR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stmlr: next-cycle property violated");

`else

`define STMLR_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define STMLR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/stmlr_pkg.sv
// ----------------------------------------------------------------------------
// stmlr_pkg
// Shared types and constants of the stereo-to-mono resampler.
// ----------------------------------------------------------------------------
package stmlr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 16;
  localparam int CNT_W     = 7;   // holds up to 127 samples per frame
  localparam int REG_IDX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RATE_W-1:0]          rate_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;

  localparam reg_idx_t REG_INPUT_RATE  = 2'd0;
  localparam reg_idx_t REG_OUTPUT_RATE = 2'd1;

  localparam rate_t RATE_RESET = 16'd48000;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FIRST = 2'd0;  // first frame after reset
  localparam kind_t KIND_RUN   = 2'd1;  // interpolate a run of samples
  localparam kind_t KIND_ERROR = 2'd2;  // too many samples, frame dropped

  typedef struct packed {
    kind_t   kind;
    sample_t current;
    count_t  count;
    rate_t   phase;
  } entry_t;

endpackage

// File: rtl/stmlr_if.sv
// ----------------------------------------------------------------------------
// stmlr_frame_if / stmlr_result_if
// Valid/ready channels for stereo frames and mono results.
// ----------------------------------------------------------------------------
interface stmlr_frame_if;
  import stmlr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface stmlr_result_if;
  import stmlr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mono_sample;
  logic    last_of_run;
  logic    ratio_error;

  modport source (output valid, mono_sample, last_of_run, ratio_error, input ready);
  modport sink (input valid, mono_sample, last_of_run, ratio_error, output ready);
endinterface

// File: rtl/stmlr_queue.sv
// ----------------------------------------------------------------------------
// stmlr_queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module stmlr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  stmlr_pkg::entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output stmlr_pkg::entry_t pop_data
);
  import stmlr_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push_fire;
  logic       pop_fire;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_fire && !pop_fire) begin
        fill <= fill + 2'd1;
      end else if (pop_fire && !push_fire) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: rtl/stmlr_front.sv
// ----------------------------------------------------------------------------
// stmlr_front
// Mixes each frame to mono, divides the phase step and classifies the frame.
// ----------------------------------------------------------------------------
`include "stereo_to_mono_linear_resampler_core_macros.svh"

module stmlr_front #(
  parameter int MAX_OUTPUTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  stmlr_frame_if.sink       frame,
  input  stmlr_pkg::rate_t  in_rate,
  input  stmlr_pkg::rate_t  out_rate,
  output logic              push_valid,
  input  logic              push_ready,
  output stmlr_pkg::entry_t push_data
);
  import stmlr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam int QUO_W = RATE_W + 1;

  logic [1:0]         fstate;
  logic               primed;
  rate_t              phase;
  sample_t            cur;
  rate_t              div_rem;
  logic [QUO_W-1:0]   div_q;
  logic [4:0]         dcnt;

  logic signed [16:0] mix_sum;
  logic signed [16:0] mix_adj;
  sample_t            mono;
  logic [QUO_W-1:0]   div_try;
  logic [QUO_W-1:0]   div_sub;
  logic               div_ge;
  logic               frame_fire;
  logic               push_fire;
  logic               too_many;
  kind_t              entry_kind;

  // average toward zero: bias negative sums by one before the shift
  assign mix_sum = {frame.left_sample[15], frame.left_sample}
                 + {frame.right_sample[15], frame.right_sample};
  assign mix_adj = mix_sum + {16'd0, mix_sum[16]};
  assign mono    = mix_adj[16:1];

  assign div_try = {div_rem, div_q[QUO_W-1]};
  assign div_ge  = (div_try >= {1'b0, in_rate});
  assign div_sub = div_try - {1'b0, in_rate};

  assign too_many   = (div_q > QUO_W'(MAX_OUTPUTS));
  assign entry_kind = !primed ? KIND_FIRST : (too_many ? KIND_ERROR : KIND_RUN);

  assign frame.ready = (fstate == F_IDLE);
  assign frame_fire  = frame.valid && frame.ready;
  assign push_valid  = (fstate == F_PUSH);
  assign push_fire   = push_valid && push_ready;

  assign push_data.kind    = entry_kind;
  assign push_data.current = cur;
  assign push_data.count   = div_q[CNT_W-1:0];
  assign push_data.phase   = phase;

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      cur <= mono;
    end
    if (frame_fire) begin
      div_q   <= {1'b0, phase} + {1'b0, out_rate};
      div_rem <= '0;
      dcnt    <= '0;
    end else if (fstate == F_DIV) begin
      div_rem <= div_ge ? div_sub[RATE_W-1:0] : div_try[RATE_W-1:0];
      div_q   <= {div_q[QUO_W-2:0], div_ge};
      dcnt    <= dcnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      primed <= 1'b0;
      phase  <= '0;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (frame_fire) begin
            fstate <= primed ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (dcnt == 5'(QUO_W - 1)) begin
            fstate <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_fire) begin
            primed <= 1'b1;
            // a dropped frame leaves the phase alone
            if (entry_kind == KIND_RUN) begin
              phase <= div_rem;
            end
            fstate <= F_IDLE;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

  `STMLR_ASSERT_IMP(a_div_rem_bound, clk, rst, fstate == F_DIV, div_rem < in_rate)
  `STMLR_ASSERT_NXT(a_phase_bound, clk, rst, push_fire && entry_kind == KIND_RUN, phase < in_rate)
  `STMLR_ASSERT_NXT(a_first_skips_div, clk, rst, frame_fire && !primed, fstate == F_PUSH)

endmodule

// File: rtl/stmlr_back.sv
// ----------------------------------------------------------------------------
// stmlr_back
// Interpolates each queued frame into mono samples through a shared
// multiplier and a bit-serial divider, and holds the result register.
// ----------------------------------------------------------------------------
`include "stereo_to_mono_linear_resampler_core_macros.svh"

module stmlr_back (
  input  logic              clk,
  input  logic              rst,
  input  stmlr_pkg::rate_t  in_rate,
  input  stmlr_pkg::rate_t  out_rate,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  stmlr_pkg::entry_t pop_data,
  stmlr_result_if.source    result
);
  import stmlr_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_ABS  = 3'd2;
  localparam logic [2:0] B_CHK  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_SUM  = 3'd5;
  localparam logic [2:0] B_EMIT = 3'd6;

  localparam int Q_W    = 17;          // quotients at or above 2^17 saturate anyway
  localparam int PROD_W = 41;
  localparam int REM_W  = RATE_W + Q_W;

  localparam sample_t SAMPLE_MAX = 16'sd32767;
  localparam sample_t SAMPLE_MIN = -16'sd32768;

  logic [2:0]               bstate;
  sample_t                  prev;
  sample_t                  cur;
  count_t                   k_left;
  logic signed [23:0]       frac;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        absv;
  logic                     neg;
  logic                     sat;
  logic [REM_W-1:0]         rem;
  logic [REM_W-2:0]         dsh;
  logic [Q_W-1:0]           quo;
  logic [4:0]               dcnt;
  sample_t                  res_sample;
  logic                     res_last;
  logic                     res_err;
  logic                     upd_prev;

  logic                     o_valid;
  sample_t                  o_sample;
  logic                     o_last;
  logic                     o_err;

  logic signed [16:0]       delta;
  logic [PROD_W-1:0]        sat_lim;
  logic                     div_ge;
  logic signed [19:0]       step;
  logic signed [19:0]       total;
  sample_t                  clipped;
  logic                     load;

  assign delta   = {cur[15], cur} - {prev[15], prev};
  assign sat_lim = {8'd0, out_rate, 17'd0};
  assign div_ge  = (rem >= {1'b0, dsh});
  assign step    = neg ? -$signed({3'd0, quo}) : $signed({3'd0, quo});
  assign total   = {{4{prev[15]}}, prev} + step;

  always_comb begin
    if (sat) begin
      clipped = neg ? SAMPLE_MIN : SAMPLE_MAX;
    end else if (total > 20'sd32767) begin
      clipped = SAMPLE_MAX;
    end else if (total < -20'sd32768) begin
      clipped = SAMPLE_MIN;
    end else begin
      clipped = total[15:0];
    end
  end

  assign pop_ready = (bstate == B_IDLE);
  assign load      = (bstate == B_EMIT) && (!o_valid || result.ready);

  assign result.valid       = o_valid;
  assign result.mono_sample = o_sample;
  assign result.last_of_run = o_last;
  assign result.ratio_error = o_err;

  // datapath
  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        cur    <= pop_data.current;
        k_left <= pop_data.count;
        frac   <= $signed({8'd0, in_rate}) - $signed({8'd0, pop_data.phase});
        if (pop_data.kind == KIND_ERROR) begin
          res_sample <= '0;
          res_err    <= 1'b1;
          upd_prev   <= 1'b0;
        end else begin
          res_sample <= pop_data.current;
          res_err    <= 1'b0;
          upd_prev   <= 1'b1;
        end
        res_last <= 1'b1;
      end
      B_MUL: begin
        prod <= PROD_W'(delta) * PROD_W'(frac);
      end
      B_ABS: begin
        neg  <= prod[PROD_W-1];
        absv <= prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
      end
      B_CHK: begin
        sat  <= (absv >= sat_lim);
        rem  <= absv[REM_W-1:0];
        dsh  <= {out_rate, 16'd0};
        quo  <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        if (div_ge) begin
          rem <= rem - {1'b0, dsh};
        end
        dsh  <= dsh >> 1;
        quo  <= {quo[Q_W-2:0], div_ge};
        dcnt <= dcnt + 5'd1;
      end
      B_SUM: begin
        res_sample <= clipped;
        res_last   <= (k_left == count_t'(1));
        res_err    <= 1'b0;
        upd_prev   <= (k_left == count_t'(1));
      end
      B_EMIT: begin
        if (load && !res_last) begin
          k_left <= k_left - count_t'(1);
          frac   <= frac + $signed({8'd0, in_rate});
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      o_sample <= res_sample;
      o_last   <= res_last;
      o_err    <= res_err;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate  <= B_IDLE;
      prev    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      case (bstate)
        B_IDLE: begin
          if (pop_valid) begin
            case (pop_data.kind)
              KIND_FIRST, KIND_ERROR: begin
                bstate <= B_EMIT;
              end
              KIND_RUN: begin
                if (pop_data.count == '0) begin
                  prev <= pop_data.current;
                end else begin
                  bstate <= B_MUL;
                end
              end
              default: begin
                bstate <= B_IDLE;
              end
            endcase
          end
        end
        B_MUL: begin
          bstate <= B_ABS;
        end
        B_ABS: begin
          bstate <= B_CHK;
        end
        B_CHK: begin
          bstate <= (absv >= sat_lim) ? B_SUM : B_DIV;
        end
        B_DIV: begin
          if (dcnt == 5'(Q_W - 1)) begin
            bstate <= B_SUM;
          end
        end
        B_SUM: begin
          bstate <= B_EMIT;
        end
        B_EMIT: begin
          if (load) begin
            if (upd_prev) begin
              prev <= cur;
            end
            bstate <= res_last ? B_IDLE : B_MUL;
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

  `STMLR_ASSERT_IMP(a_div_invariant, clk, rst, bstate == B_DIV, rem < (REM_W'(dsh) << 1))
  `STMLR_ASSERT_IMP(a_run_nonempty, clk, rst, bstate == B_MUL, k_left != '0)
  `STMLR_ASSERT_IMP(a_error_shape, clk, rst, load && res_err, res_last && (res_sample == '0))
  `STMLR_ASSERT_NXT(a_run_updates_prev, clk, rst, load && upd_prev, prev == $past(cur))

endmodule

// File: rtl/stereo_to_mono_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// stereo_to_mono_linear_resampler_core
// Stereo-to-mono mixer with linear-interpolation rate conversion.
// ----------------------------------------------------------------------------
// Each stereo frame is averaged to mono and turned into zero or more mono
// samples (one error result when a frame would need more than MAX_OUTPUTS).
// The front takes a frame, runs the bit-serial phase division (the first
// frame after reset skips it) and hands the frame to a two-entry queue,
// waiting while the queue is full. The back picks up each frame and works
// through each mono sample in steps (multiply, absolute value, range check,
// 17-step bit-serial divide, sum, emit; a saturating sample skips the
// divide), waiting in emit while the result register holds an untaken
// sample; it takes the next frame only once a frame's last result is out. Front and
// back overlap through the queue, and the result register lets the back
// move on while a finished sample waits. Write the rate registers only while
// the block is idle; a zero write is ignored.
module stereo_to_mono_linear_resampler_core #(
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  stmlr_frame_if.sink                          frame,
  stmlr_result_if.source                       result,
  input  logic                                 cfg_we,
  input  logic [stmlr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [stmlr_pkg::RATE_W-1:0]         cfg_data
);
  import stmlr_pkg::*;

  rate_t  in_rate;
  rate_t  out_rate;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // drop zero writes and unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= RATE_RESET;
      out_rate <= RATE_RESET;
    end else if (cfg_we && (cfg_data != '0)) begin
      case (cfg_index)
        REG_INPUT_RATE: begin
          in_rate <= cfg_data;
        end
        REG_OUTPUT_RATE: begin
          out_rate <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  stmlr_front #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .in_rate     (in_rate),
    .out_rate    (out_rate),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  stmlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  stmlr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_rate     (in_rate),
    .out_rate    (out_rate),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .result      (result)
  );

endmodule
